FILE: sv/sequenced_replay_ring_buffer_assert.svh
// assertion macros for the replay ring buffer checker
`ifndef SEQUENCED_REPLAY_RING_BUFFER_ASSERT_SVH
`define SEQUENCED_REPLAY_RING_BUFFER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define SRRB_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("srrb: property violated");

// consequent checked in the cycle after the antecedent
`define SRRB_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("srrb: property violated");

`endif

FILE: sv/srrb_pkg.sv
`default_nettype none

package srrb_pkg;

    // default geometry
    localparam int SLOTS_DEF    = 16;
    localparam int SESSIONS_DEF = 1024;

    // field widths
    localparam int OP_W      = 2;
    localparam int SESSION_W = 10;
    localparam int SEQ_W     = 32;
    localparam int HANDLE_W  = 32;
    localparam int LENGTH_W  = 16;
    localparam int STATUS_W  = 3;

    typedef enum logic [OP_W-1:0] {
        OP_STORE = 2'd0,
        OP_GET   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED    = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_NODATA    = 3'd2,
        ST_TOONEW    = 3'd3,
        ST_TOOOLD    = 3'd4,
        ST_FOUND     = 3'd5
    } t_status;

    // which slot the entry memory reads
    typedef enum logic [1:0] {
        RD_HEAD   = 2'd0,
        RD_OLDEST = 2'd1,
        RD_NEXT   = 2'd2
    } t_rd_sel;

    // source of the returned sequence
    typedef enum logic [1:0] {
        SEQ_ZERO = 2'd0,
        SEQ_HEAD = 2'd1,
        SEQ_OLD  = 2'd2,
        SEQ_RD   = 2'd3
    } t_seq_sel;

    typedef struct packed {
        logic     cap;
        logic     quot_ld;
        logic     sess_ld;
        logic     ptr_rd;
        logic     init_wr;
        logic     clr_wr;
        logic     append;
        logic     slot_rd;
        t_rd_sel  rd_sel;
        logic     head_ld;
        logic     old_ld;
        logic     res_ld;
        t_status  res_status;
        t_seq_sel res_seq;
        logic     out_ld;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic empty;
        logic seq_gt_rd;
        logic seq_lt_rd;
        logic seq_eq_rd;
        logic chk_is_head;
        logic init_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

FILE: sv/sequenced_replay_ring_buffer.sv
// Per-session replay ring: each of SESSIONS sessions keeps up to SLOTS-1
// sequence-numbered entries (handle and length) in a ring with one empty
// sentinel slot. A request carries op (store, get, clear), a session
// (reduced modulo SESSIONS) and the entry fields, and yields exactly one
// result. Requests are handled one at a time, and a get walks the ring
// one slot per cycle through the single read port of the entry memory.
// The result sits in an output register, so the next request is accepted
// while it waits to be taken. After reset the pointer memory is cleared
// one session per cycle, and no request is taken until that is done.
`default_nettype none

module sequenced_replay_ring_buffer #(
    parameter int SLOTS    = srrb_pkg::SLOTS_DEF,
    parameter int SESSIONS = srrb_pkg::SESSIONS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [srrb_pkg::OP_W-1:0]       i_op,
    input  logic [srrb_pkg::SESSION_W-1:0]  i_session,
    input  logic [srrb_pkg::SEQ_W-1:0]      i_seq_in,
    input  logic [srrb_pkg::HANDLE_W-1:0]   i_handle_in,
    input  logic [srrb_pkg::LENGTH_W-1:0]   i_length_in,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [srrb_pkg::STATUS_W-1:0]   o_status,
    output logic [srrb_pkg::SEQ_W-1:0]      o_seq_out,
    output logic [srrb_pkg::HANDLE_W-1:0]   o_handle_out,
    output logic [srrb_pkg::LENGTH_W-1:0]   o_length_out
);
    import srrb_pkg::*;

    // commands from the sequencer, status back from the datapath
    t_cmd cmd;
    t_sts sts;

    // sequencer: reset clear sweep, session mapping, pointer read,
    // head/oldest checks and the linear ring walk of a get
    srrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // pointer and entry memories, compares and the result registers
    srrb_datapath #(
        .SLOTS    (SLOTS),
        .SESSIONS (SESSIONS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_op         (i_op),
        .i_session    (i_session),
        .i_seq_in     (i_seq_in),
        .i_handle_in  (i_handle_in),
        .i_length_in  (i_length_in),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_status     (o_status),
        .o_seq_out    (o_seq_out),
        .o_handle_out (o_handle_out),
        .o_length_out (o_length_out)
    );

endmodule

`default_nettype wire

FILE: sv/srrb_ctrl.sv
`default_nettype none

module srrb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  srrb_pkg::t_sts    i_sts,
    output srrb_pkg::t_cmd    o_cmd
);
    import srrb_pkg::*;

    typedef enum logic [9:0] {
        S_INIT  = 10'b00_0000_0001,
        S_IDLE  = 10'b00_0000_0010,
        S_MAP   = 10'b00_0000_0100,
        S_BASE  = 10'b00_0000_1000,
        S_PTR   = 10'b00_0001_0000,
        S_PTRW  = 10'b00_0010_0000,
        S_HEADW = 10'b00_0100_0000,
        S_OLDW  = 10'b00_1000_0000,
        S_SCAN  = 10'b01_0000_0000,
        S_RESP  = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_INIT: begin
                cmd.init_wr = 1'b1;
                if (i_sts.init_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.cap = 1'b1;
                    n_state = S_MAP;
                end
            end
            S_MAP: begin
                cmd.quot_ld = 1'b1;
                n_state     = S_BASE;
            end
            S_BASE: begin
                cmd.sess_ld = 1'b1;
                n_state     = S_PTR;
            end
            S_PTR: begin
                cmd.ptr_rd = 1'b1;
                n_state    = S_PTRW;
            end
            S_PTRW: begin
                case (i_sts.op)
                    OP_STORE: begin
                        if (i_sts.empty) begin
                            cmd.append     = 1'b1;
                            cmd.res_ld     = 1'b1;
                            cmd.res_status = ST_STORED;
                            n_state        = S_RESP;
                        end else begin
                            cmd.slot_rd = 1'b1;
                            cmd.rd_sel  = RD_HEAD;
                            n_state     = S_HEADW;
                        end
                    end
                    OP_GET: begin
                        if (i_sts.empty) begin
                            cmd.res_ld     = 1'b1;
                            cmd.res_status = ST_NODATA;
                            n_state        = S_RESP;
                        end else begin
                            cmd.slot_rd = 1'b1;
                            cmd.rd_sel  = RD_HEAD;
                            n_state     = S_HEADW;
                        end
                    end
                    OP_CLEAR: begin
                        cmd.clr_wr     = 1'b1;
                        cmd.res_ld     = 1'b1;
                        cmd.res_status = ST_STORED;
                        n_state        = S_RESP;
                    end
                    default: begin
                        cmd.res_ld     = 1'b1;
                        cmd.res_status = ST_STORED;
                        n_state        = S_RESP;
                    end
                endcase
            end
            S_HEADW: begin
                cmd.head_ld = 1'b1;
                if (i_sts.op == OP_STORE) begin
                    cmd.res_ld = 1'b1;
                    n_state    = S_RESP;
                    if (!i_sts.seq_gt_rd) begin
                        cmd.res_status = ST_DUPLICATE;
                        cmd.res_seq    = SEQ_HEAD;
                    end else begin
                        cmd.append     = 1'b1;
                        cmd.res_status = ST_STORED;
                    end
                end else if (i_sts.seq_gt_rd) begin
                    cmd.res_ld     = 1'b1;
                    cmd.res_status = ST_TOONEW;
                    cmd.res_seq    = SEQ_HEAD;
                    n_state        = S_RESP;
                end else begin
                    cmd.slot_rd = 1'b1;
                    cmd.rd_sel  = RD_OLDEST;
                    n_state     = S_OLDW;
                end
            end
            S_OLDW: begin
                cmd.old_ld = 1'b1;
                if (i_sts.seq_lt_rd) begin
                    cmd.res_ld     = 1'b1;
                    cmd.res_status = ST_TOOOLD;
                    cmd.res_seq    = SEQ_OLD;
                    n_state        = S_RESP;
                end else if (i_sts.seq_eq_rd) begin
                    cmd.res_ld     = 1'b1;
                    cmd.res_status = ST_FOUND;
                    cmd.res_seq    = SEQ_RD;
                    n_state        = S_RESP;
                end else if (i_sts.chk_is_head) begin
                    cmd.res_ld     = 1'b1;
                    cmd.res_status = ST_TOONEW;
                    cmd.res_seq    = SEQ_HEAD;
                    n_state        = S_RESP;
                end else begin
                    cmd.slot_rd = 1'b1;
                    cmd.rd_sel  = RD_NEXT;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.seq_eq_rd) begin
                    cmd.res_ld     = 1'b1;
                    cmd.res_status = ST_FOUND;
                    cmd.res_seq    = SEQ_RD;
                    n_state        = S_RESP;
                end else if (i_sts.seq_lt_rd) begin
                    // gap in the stored sequence
                    cmd.res_ld     = 1'b1;
                    cmd.res_status = ST_TOOOLD;
                    cmd.res_seq    = SEQ_OLD;
                    n_state        = S_RESP;
                end else if (i_sts.chk_is_head) begin
                    cmd.res_ld     = 1'b1;
                    cmd.res_status = ST_TOONEW;
                    cmd.res_seq    = SEQ_HEAD;
                    n_state        = S_RESP;
                end else begin
                    cmd.slot_rd = 1'b1;
                    cmd.rd_sel  = RD_NEXT;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    cmd.out_ld = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    assign o_cmd      = cmd;
    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

FILE: sv/srrb_datapath.sv
`default_nettype none

module srrb_datapath #(
    parameter int SLOTS    = srrb_pkg::SLOTS_DEF,
    parameter int SESSIONS = srrb_pkg::SESSIONS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  srrb_pkg::t_cmd                  i_cmd,
    output srrb_pkg::t_sts                  o_sts,
    input  logic [srrb_pkg::OP_W-1:0]       i_op,
    input  logic [srrb_pkg::SESSION_W-1:0]  i_session,
    input  logic [srrb_pkg::SEQ_W-1:0]      i_seq_in,
    input  logic [srrb_pkg::HANDLE_W-1:0]   i_handle_in,
    input  logic [srrb_pkg::LENGTH_W-1:0]   i_length_in,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [srrb_pkg::STATUS_W-1:0]   o_status,
    output logic [srrb_pkg::SEQ_W-1:0]      o_seq_out,
    output logic [srrb_pkg::HANDLE_W-1:0]   o_handle_out,
    output logic [srrb_pkg::LENGTH_W-1:0]   o_length_out
);
    import srrb_pkg::*;

    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int SESS_W    = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
    localparam int ADDR_W    = $clog2(SESSIONS * SLOTS);
    localparam int MAP_SHIFT = 2 * SESSION_W;
    localparam int MAP_MUL_W = MAP_SHIFT + 1;
    localparam int PROD_W    = SESSION_W + MAP_MUL_W;
    localparam int CALC_W    = 2 * SESSION_W;
    localparam logic [MAP_MUL_W-1:0] MAP_MUL   = MAP_MUL_W'((1 << MAP_SHIFT) / SESSIONS);
    localparam logic [SLOT_W-1:0]    LAST_SLOT = SLOT_W'(SLOTS - 1);
    localparam logic [SESS_W-1:0]    LAST_SESS = SESS_W'(SESSIONS - 1);

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        next_slot = (s == LAST_SLOT) ? '0 : s + SLOT_W'(1);
    endfunction

    // captured request
    t_op                  r_op;
    logic [SESSION_W-1:0] r_session;
    logic [SEQ_W-1:0]     r_seq;
    logic [HANDLE_W-1:0]  r_handle;
    logic [LENGTH_W-1:0]  r_length;

    // session mapping and ring base
    logic [SESSION_W-1:0] r_quot;
    logic [SESS_W-1:0]    r_sess;
    logic [ADDR_W-1:0]    r_base;
    logic [SESS_W-1:0]    r_init_idx;

    // pointer memory: {newest, sentinel} per session
    logic [2*SLOT_W-1:0]  mem_ptr [SESSIONS];
    logic [2*SLOT_W-1:0]  r_ptr_q;

    // entry memory
    logic [SEQ_W-1:0]     mem_seq    [SESSIONS*SLOTS];
    logic [HANDLE_W-1:0]  mem_handle [SESSIONS*SLOTS];
    logic [LENGTH_W-1:0]  mem_length [SESSIONS*SLOTS];
    logic [SEQ_W-1:0]     r_rd_seq;
    logic [HANDLE_W-1:0]  r_rd_handle;
    logic [LENGTH_W-1:0]  r_rd_length;
    logic [SLOT_W-1:0]    r_chk;

    logic [SEQ_W-1:0]     r_head_seq;
    logic [SEQ_W-1:0]     r_old_seq;

    // pending result and output register
    t_status              r_res_status;
    logic [SEQ_W-1:0]     r_res_seq;
    logic [HANDLE_W-1:0]  r_res_handle;
    logic [LENGTH_W-1:0]  r_res_length;
    logic                 r_out_vld;
    t_status              r_out_status;
    logic [SEQ_W-1:0]     r_out_seq;
    logic [HANDLE_W-1:0]  r_out_handle;
    logic [LENGTH_W-1:0]  r_out_length;

    logic [PROD_W-1:0]    quot_prod;
    logic [CALC_W-1:0]    sub_prod;
    logic [SESSION_W-1:0] rem;
    logic [CALC_W-1:0]    rem_ext;
    logic [CALC_W-1:0]    red;
    logic [SLOT_W-1:0]    head;
    logic [SLOT_W-1:0]    tail;
    logic [SLOT_W-1:0]    nh;
    logic [SLOT_W-1:0]    n_tail;
    logic [SLOT_W-1:0]    rd_slot;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ADDR_W-1:0]    wr_addr;
    logic                 ptr_we;
    logic [SESS_W-1:0]    ptr_waddr;
    logic [2*SLOT_W-1:0]  ptr_wdata;
    logic [SEQ_W-1:0]     head_seq_now;
    logic [SEQ_W-1:0]     old_seq_now;
    logic [SEQ_W-1:0]     n_res_seq;
    logic                 out_free;

    // session modulo by reciprocal multiply, one correction step
    assign quot_prod = PROD_W'(r_session) * PROD_W'(MAP_MUL);
    assign sub_prod  = CALC_W'(r_quot) * CALC_W'(SESSIONS);
    assign rem       = r_session - sub_prod[SESSION_W-1:0];
    assign rem_ext   = CALC_W'(rem);
    assign red       = (rem_ext >= CALC_W'(SESSIONS)) ? rem_ext - CALC_W'(SESSIONS) : rem_ext;

    assign head   = r_ptr_q[2*SLOT_W-1:SLOT_W];
    assign tail   = r_ptr_q[SLOT_W-1:0];
    assign nh     = next_slot(head);
    assign n_tail = (nh == tail) ? next_slot(tail) : tail;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_HEAD:   rd_slot = head;
            RD_OLDEST: rd_slot = next_slot(tail);
            RD_NEXT:   rd_slot = next_slot(r_chk);
            default:   rd_slot = head;
        endcase
    end

    assign rd_addr = r_base + ADDR_W'(rd_slot);
    assign wr_addr = r_base + ADDR_W'(nh);

    assign ptr_we    = i_cmd.init_wr | i_cmd.clr_wr | i_cmd.append;
    assign ptr_waddr = i_cmd.init_wr ? r_init_idx : r_sess;
    assign ptr_wdata = i_cmd.append ? {nh, n_tail} : '0;

    assign head_seq_now = i_cmd.head_ld ? r_rd_seq : r_head_seq;
    assign old_seq_now  = i_cmd.old_ld ? r_rd_seq : r_old_seq;

    always_comb begin
        case (i_cmd.res_seq)
            SEQ_ZERO: n_res_seq = '0;
            SEQ_HEAD: n_res_seq = head_seq_now;
            SEQ_OLD:  n_res_seq = old_seq_now;
            SEQ_RD:   n_res_seq = r_rd_seq;
            default:  n_res_seq = '0;
        endcase
    end

    assign out_free = !r_out_vld || i_out_ready;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_idx <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.init_wr) begin
                r_init_idx <= r_init_idx + SESS_W'(1);
            end
            if (i_cmd.out_ld) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op      <= t_op'(i_op);
            r_session <= i_session;
            r_seq     <= i_seq_in;
            r_handle  <= i_handle_in;
            r_length  <= i_length_in;
        end
        if (i_cmd.quot_ld) begin
            r_quot <= quot_prod[MAP_SHIFT +: SESSION_W];
        end
        if (i_cmd.sess_ld) begin
            r_sess <= red[SESS_W-1:0];
        end
        if (i_cmd.ptr_rd) begin
            r_base <= ADDR_W'(r_sess) * ADDR_W'(SLOTS);
        end
        if (i_cmd.slot_rd) begin
            r_chk <= rd_slot;
        end
        if (i_cmd.head_ld) begin
            r_head_seq <= r_rd_seq;
        end
        if (i_cmd.old_ld) begin
            r_old_seq <= r_rd_seq;
        end
        if (i_cmd.res_ld) begin
            r_res_status <= i_cmd.res_status;
            r_res_seq    <= n_res_seq;
            r_res_handle <= (i_cmd.res_status == ST_FOUND) ? r_rd_handle : '0;
            r_res_length <= (i_cmd.res_status == ST_FOUND) ? r_rd_length : '0;
        end
        if (i_cmd.out_ld) begin
            r_out_status <= r_res_status;
            r_out_seq    <= r_res_seq;
            r_out_handle <= r_res_handle;
            r_out_length <= r_res_length;
        end
    end

    // pointer memory
    always_ff @(posedge i_clk) begin
        if (ptr_we) begin
            mem_ptr[ptr_waddr] <= ptr_wdata;
        end
        if (i_cmd.ptr_rd) begin
            r_ptr_q <= mem_ptr[r_sess];
        end
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            mem_seq[wr_addr]    <= r_seq;
            mem_handle[wr_addr] <= r_handle;
            mem_length[wr_addr] <= r_length;
        end
        if (i_cmd.slot_rd) begin
            r_rd_seq    <= mem_seq[rd_addr];
            r_rd_handle <= mem_handle[rd_addr];
            r_rd_length <= mem_length[rd_addr];
        end
    end

    assign o_sts.op          = r_op;
    assign o_sts.empty       = (head == tail);
    assign o_sts.seq_gt_rd   = (r_seq > r_rd_seq);
    assign o_sts.seq_lt_rd   = (r_seq < r_rd_seq);
    assign o_sts.seq_eq_rd   = (r_seq == r_rd_seq);
    assign o_sts.chk_is_head = (r_chk == head);
    assign o_sts.init_last   = (r_init_idx == LAST_SESS);
    assign o_sts.out_free    = out_free;

    assign o_out_valid  = r_out_vld;
    assign o_status     = r_out_status;
    assign o_seq_out    = r_out_seq;
    assign o_handle_out = r_out_handle;
    assign o_length_out = r_out_length;

endmodule

`default_nettype wire

FILE: sv/srrb_checker.sv
`default_nettype none
`include "sequenced_replay_ring_buffer_assert.svh"

module srrb_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [srrb_pkg::STATUS_W-1:0]   o_status,
    input logic [srrb_pkg::SEQ_W-1:0]      o_seq_out,
    input logic [srrb_pkg::HANDLE_W-1:0]   o_handle_out,
    input logic [srrb_pkg::LENGTH_W-1:0]   o_length_out
);
    import srrb_pkg::*;

    // requests accepted but not yet answered
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    // result waiting, result other than found, empty payload
    logic out_wait;
    logic out_plain;
    logic payload_zero;

    always_comb begin
        n_cnt = r_cnt;
        if (i_in_valid && o_in_ready) begin
            n_cnt = n_cnt + 2'd1;
        end
        if (o_out_valid && i_out_ready) begin
            n_cnt = n_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign out_wait     = o_out_valid && !i_out_ready;
    assign out_plain    = o_out_valid && (o_status != ST_FOUND);
    assign payload_zero = (o_handle_out == '0) && (o_length_out == '0);

    `SRRB_ASSERT_NEXT(a_out_hold, out_wait, o_out_valid && $stable(o_status) && $stable(o_seq_out))
    `SRRB_ASSERT_IMPL(a_out_has_request, o_out_valid, r_cnt != 2'd0)
    `SRRB_ASSERT_IMPL(a_one_in_work, o_in_ready, r_cnt <= 2'd1)
    `SRRB_ASSERT_IMPL(a_status_code, o_out_valid, o_status <= ST_FOUND)
    `SRRB_ASSERT_IMPL(a_payload_only_found, out_plain, payload_zero)

endmodule

bind sequenced_replay_ring_buffer srrb_checker u_srrb_checker (.*);

`default_nettype wire
